// ----- src/ibif_pkg.sv -----
package ibif_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int FUNC_W    = 2;
    localparam int START_W   = 48;
    localparam int COUNT_W   = 24;
    localparam int HANDLE_W  = 16;
    localparam int STATUS_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_SEARCH = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    in_ready;
        logic    push;
        logic    pop;
        logic    srch_init;
        logic    step;
        logic    res_set;
        t_status res_code;
        logic    res_hit;
        logic    out_ld;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        t_func func;
        logic  full;
        logic  empty;
        logic  win_empty;
        logic  hit;
        logic  out_free;
    } t_sts;

endpackage

// ----- src/ibif_if.sv -----
interface ibif_req_if
    import ibif_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [START_W-1:0]  block_start;
    logic [COUNT_W-1:0]  block_count;
    logic [HANDLE_W-1:0] block_handle;
    logic [START_W-1:0]  query_index;

    modport source (
        output valid, func, block_start, block_count, block_handle, query_index,
        input  ready
    );
    modport sink (
        input  valid, func, block_start, block_count, block_handle, query_index,
        output ready
    );
endinterface

interface ibif_rsp_if
    import ibif_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] found_handle;

    modport source (
        output valid, status, found_handle,
        input  ready
    );
    modport sink (
        input  valid, status, found_handle,
        output ready
    );
endinterface

// ----- src/ibif_ram.sv -----
module ibif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/ibif_ctrl.sv -----
module ibif_ctrl
    import ibif_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.func)
                    FN_PUSH: begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = i_sts.full ? ST_FULL : ST_OK;
                        o_cmd.push     = !i_sts.full;
                        n_state        = S_DONE;
                    end
                    FN_POP: begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = i_sts.empty ? ST_EMPTY : ST_OK;
                        o_cmd.pop      = !i_sts.empty;
                        n_state        = S_DONE;
                    end
                    FN_SEARCH: begin
                        o_cmd.srch_init = 1'b1;
                        n_state         = S_PROBE;
                    end
                    default: begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_code = ST_OK;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_PROBE: begin
                if (i_sts.win_empty) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_NOTFOUND;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = ST_OK;
                    o_cmd.res_hit  = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_PROBE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- src/ibif_dp.sv -----
module ibif_dp
    import ibif_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibif_req_if.sink   i_req,
    ibif_rsp_if.source o_rsp,
    input  t_cmd       i_cmd,
    output t_sts       o_sts
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int EW = START_W + COUNT_W + HANDLE_W;

    logic [FUNC_W-1:0]   r_func;
    logic [START_W-1:0]  r_start;
    logic [COUNT_W-1:0]  r_count;
    logic [HANDLE_W-1:0] r_handle;
    logic [START_W-1:0]  r_query;
    logic [PW-1:0]       r_head;
    logic [OW-1:0]       r_occ;
    logic [OW-1:0]       r_lo;
    logic [OW-1:0]       r_hip1;
    t_status             r_res_status;
    logic [HANDLE_W-1:0] r_res_handle;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [HANDLE_W-1:0] r_out_handle;

    logic [PW:0]         w_wsum;
    logic [PW-1:0]       w_waddr;
    logic [OW:0]         w_msum;
    logic [OW-1:0]       w_mid;
    logic [PW:0]         w_rsum;
    logic [PW-1:0]       w_raddr;
    logic [EW-1:0]       w_wdata;
    logic [EW-1:0]       w_rdata;
    logic [START_W-1:0]  w_st;
    logic [COUNT_W-1:0]  w_cnt;
    logic [HANDLE_W-1:0] w_hdl;
    logic [START_W:0]    w_end;
    logic                w_below;
    logic                w_hit;
    logic                w_accept;

    assign w_accept = i_req.valid && i_cmd.in_ready;

    assign w_wsum  = {1'b0, r_head} + {1'b0, r_occ[PW-1:0]};
    assign w_waddr = (w_wsum >= (PW+1)'(DEPTH)) ? PW'(w_wsum - (PW+1)'(DEPTH))
                                                 : w_wsum[PW-1:0];

    // midpoint of the inclusive window lo..hip1-1
    assign w_msum  = {1'b0, r_lo} + {1'b0, r_hip1} - (OW+1)'(1);
    assign w_mid   = w_msum[OW:1];
    assign w_rsum  = {1'b0, r_head} + {1'b0, w_mid[PW-1:0]};
    assign w_raddr = (w_rsum >= (PW+1)'(DEPTH)) ? PW'(w_rsum - (PW+1)'(DEPTH))
                                                 : w_rsum[PW-1:0];

    assign w_wdata = {r_start, r_count, r_handle};

    ibif_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign {w_st, w_cnt, w_hdl} = w_rdata;
    assign w_end   = {1'b0, w_st} + (START_W+1)'(w_cnt);
    assign w_below = r_query < w_st;
    assign w_hit   = !w_below && ({1'b0, r_query} < w_end);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_req.func;
            r_start  <= i_req.block_start;
            r_count  <= i_req.block_count;
            r_handle <= i_req.block_handle;
            r_query  <= i_req.query_index;
        end
        if (i_cmd.srch_init) begin
            r_lo   <= '0;
            r_hip1 <= r_occ;
        end else if (i_cmd.step) begin
            if (w_below) begin
                r_hip1 <= w_mid;
            end else begin
                r_lo <= w_mid + OW'(1);
            end
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_handle <= i_cmd.res_hit ? w_hdl : '0;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_occ <= r_occ + OW'(1);
            end else if (i_cmd.pop) begin
                r_occ  <= r_occ - OW'(1);
                r_head <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready        = i_cmd.in_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.found_handle = r_out_handle;

    assign o_sts.in_valid  = i_req.valid;
    assign o_sts.func      = t_func'(r_func);
    assign o_sts.full      = (r_occ == OW'(DEPTH));
    assign o_sts.empty     = (r_occ == '0);
    assign o_sts.win_empty = (r_lo >= r_hip1);
    assign o_sts.hit       = w_hit;
    assign o_sts.out_free  = !r_out_valid || o_rsp.ready;
endmodule

// ----- src/interval_block_index_fifo.sv -----
// FIFO table of index ranges (start, count, handle), DEPTH entries deep, held in one
// RAM with registered read. Push appends at the tail, pop drops the oldest entry, and
// search does a binary search over the live entries (which must be kept ordered by
// start) and returns the handle of the entry covering the query index, or not-found.
// Every transaction returns exactly one response. Push, pop and an undefined func set
// their result in the execute state and load it into the response register in the done
// state. Search sets up the window, then probes: each probe is one RAM read followed by
// a compare state, until an entry matches or the window is empty (not-found).
// One transaction is in flight at a time; the next one is accepted the cycle after the
// previous response is loaded, even if that response has not been taken yet. A new
// response waits while the previous one is still held in the response register.
module interval_block_index_fifo
    import ibif_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ibif_req_if.sink   i_req,
    ibif_rsp_if.source o_rsp
);
    t_cmd w_cmd;
    t_sts w_sts;

    ibif_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ibif_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );
endmodule

// ----- verif/interval_block_index_fifo_tb.sv -----
`timescale 1ns / 1ps

import ibif_pkg::*;

localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;

typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [START_W-1:0]  start;
    logic [COUNT_W-1:0]  count;
    logic [HANDLE_W-1:0] handle;
    logic [START_W-1:0]  query;
} t_table_op;

typedef struct packed {
    t_status             status;
    logic [HANDLE_W-1:0] handle;
} t_table_result;

class range_table_scoreboard;
    logic [START_W-1:0]  start_mem  [DEPTH_DEF];
    logic [COUNT_W-1:0]  count_mem  [DEPTH_DEF];
    logic [HANDLE_W-1:0] handle_mem [DEPTH_DEF];
    int unsigned         head;
    int unsigned         occ;
    t_table_result       expected_results [$];
    int                  errors;

    function int pending();
        return expected_results.size();
    endfunction

    function t_table_result predict(t_table_op op);
        t_table_result res;
        int            lo;
        int            hi;
        int            mid;
        int unsigned   slot;
        logic [START_W:0] range_end;
        bit            hit;
        res.status = ST_OK;
        res.handle = '0;
        case (op.func)
            FN_PUSH: begin
                if (occ >= DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    slot = (head + occ) % DEPTH_DEF;
                    start_mem[slot]  = op.start;
                    count_mem[slot]  = op.count;
                    handle_mem[slot] = op.handle;
                    occ++;
                end
            end
            FN_POP: begin
                if (occ == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    head = (head + 1) % DEPTH_DEF;
                    occ--;
                end
            end
            FN_SEARCH: begin
                lo  = 0;
                hi  = int'(occ) - 1;
                hit = 1'b0;
                while (lo <= hi && !hit) begin
                    mid = (lo + hi) / 2;
                    slot = (head + mid) % DEPTH_DEF;
                    range_end = {1'b0, start_mem[slot]} + count_mem[slot];
                    if (op.query >= start_mem[slot] && {1'b0, op.query} < range_end) begin
                        hit = 1'b1;
                        res.handle = handle_mem[slot];
                    end else if (op.query < start_mem[slot]) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
                if (!hit) begin
                    res.status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function void note_op(t_table_op op);
        expected_results.push_back(predict(op));
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle);
        t_table_result exp_res;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected response status %0d handle %h", $time, status, handle);
            errors++;
        end else begin
            exp_res = expected_results.pop_front();
            if (status !== exp_res.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, exp_res.status, status);
                errors++;
            end
            if (handle !== exp_res.handle) begin
                $display("%0t: found_handle mismatch, expected %h actual %h",
                         $time, exp_res.handle, handle);
                errors++;
            end
        end
    endfunction
endclass

module interval_block_index_fifo_tb;

    localparam int N_ITEMS      = 1550;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 800000;

    logic clk;
    logic rst_n;
    int unsigned cycles;
    int unsigned sent;
    bit burst;
    logic [START_W-1:0] next_start;

    range_table_scoreboard sb = new();

    ibif_req_if req_if ();
    ibif_rsp_if rsp_if ();

    interval_block_index_fifo i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("** interval_block_index_fifo: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.status, rsp_if.found_handle);
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [START_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[START_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return COUNT_W'($urandom);
        return COUNT_W'($urandom_range(1, 1000));
    endfunction

    function automatic t_table_op random_op(logic [FUNC_W-1:0] f);
        t_table_op op;
        op.func   = f;
        op.start  = rand48();
        op.count  = rand_count();
        op.handle = HANDLE_W'($urandom);
        op.query  = rand48();
        return op;
    endfunction

    // mostly indices inside or just around a live entry
    function automatic logic [START_W-1:0] pick_query();
        int unsigned        r;
        int unsigned        slot;
        logic [START_W-1:0] st;
        logic [COUNT_W-1:0] cnt;
        r = $urandom_range(0, 9);
        if (sb.occ == 0 || r == 0) return rand48();
        slot = (sb.head + $urandom_range(0, sb.occ - 1)) % DEPTH_DEF;
        st   = sb.start_mem[slot];
        cnt  = sb.count_mem[slot];
        case (r)
            1: return st - 1;
            2: return st + cnt;
            3: return st + cnt - 1;
            default: return st + ((cnt == 0) ? 0 : $urandom_range(0, cnt - 1));
        endcase
    endfunction

    task automatic send_op(input t_table_op op);
        int unsigned gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= op.func;
        req_if.block_start  <= op.start;
        req_if.block_count  <= op.count;
        req_if.block_handle <= op.handle;
        req_if.query_index  <= op.query;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.note_op(op);
        sent++;
    endtask

    task automatic send_fields(input logic [FUNC_W-1:0] f, input logic [START_W-1:0] s,
                               input logic [COUNT_W-1:0] c, input logic [HANDLE_W-1:0] h,
                               input logic [START_W-1:0] q);
        t_table_op op;
        op.func   = f;
        op.start  = s;
        op.count  = c;
        op.handle = h;
        op.query  = q;
        send_op(op);
    endtask

    task automatic push_sorted();
        t_table_op op;
        op = random_op(FN_PUSH);
        op.start = next_start + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5000));
        next_start = op.start + op.count;
        send_op(op);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // response side: random stalls, calm stretches, one long hold-off
    initial begin
        int unsigned stall;
        bit          hold_done;
        rsp_if.ready = 1'b0;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!hold_done && sent >= HOLD_AT) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                stall = (((cycles / 400) % 3) == 0) ? 0 : idle_len();
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        t_table_op   op;
        int unsigned fill;
        int unsigned mix;
        int unsigned r;
        int unsigned episode;
        bit          paused;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = '0;
        req_if.block_start  = '0;
        req_if.block_count  = '0;
        req_if.block_handle = '0;
        req_if.query_index  = '0;
        sent    = 0;
        burst   = 1'b0;
        paused  = 1'b0;
        episode = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_fields(FN_SEARCH, '0, '0, '0, '0);
        send_fields(FN_POP, '1, '1, '1, '1);
        send_fields(FN_UNDEF, '1, '1, '1, '1);
        send_fields(FN_PUSH, '0, 24'd1, 16'hFFFF, '1);
        send_fields(FN_PUSH, 48'd10, '0, 16'd1, '0);         // covers nothing
        send_fields(FN_PUSH, 48'd100, '1, 16'h1234, '0);
        send_fields(FN_PUSH, '1, '1, 16'hA5A5, '0);
        send_fields(FN_SEARCH, '0, '0, '0, 48'd0);
        send_fields(FN_SEARCH, '1, '1, '1, 48'd10);
        send_fields(FN_SEARCH, '0, '0, '0, 48'd100 + 48'hFFFFFE);
        send_fields(FN_SEARCH, '0, '0, '0, 48'd100 + 48'hFFFFFF);
        send_fields(FN_SEARCH, '0, '0, '0, '1);
        send_fields(FN_SEARCH, '0, '0, '0, 48'd5);
        send_fields(FN_SEARCH, '0, '0, '0, 48'd99);
        send_fields(FN_UNDEF, '0, '0, '0, '0);
        send_fields(FN_POP, '0, '0, '0, '0);
        send_fields(FN_SEARCH, '0, '0, '0, 48'd0);
        send_fields(FN_PUSH, 48'd50, 24'd3, 16'h0F0F, '0);   // breaks start order
        send_fields(FN_SEARCH, '0, '0, '0, 48'd51);
        send_fields(FN_SEARCH, '0, '0, '0, 48'd100);
        repeat (5) send_fields(FN_POP, '0, '0, '0, '0);

        while (sent < N_ITEMS) begin
            if (!paused && sent >= N_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                wait_drained();
            end
            burst = ($urandom_range(0, 3) == 0);
            while (sb.occ > 0) send_op(random_op(FN_POP));
            repeat ($urandom_range(0, 1)) send_op(random_op(FN_POP));

            next_start = rand48();
            if (next_start > 48'hFF00_0000_0000) begin
                next_start = next_start - 48'h0100_0000_0000;
            end
            fill = (episode == 0 || $urandom_range(0, 4) == 0) ?
                   DEPTH_DEF + $urandom_range(1, 3) : $urandom_range(1, 40);
            repeat (fill) push_sorted();

            mix = $urandom_range(20, 80);
            repeat (mix) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    op = random_op(FN_SEARCH);
                    op.query = pick_query();
                    send_op(op);
                end else if (r < 65) begin
                    push_sorted();
                end else if (r < 80) begin
                    send_op(random_op(FN_POP));
                end else if (r < 88) begin
                    send_op(random_op(FN_SEARCH));
                end else if (r < 94) begin
                    send_op(random_op(FN_PUSH));
                end else begin
                    send_op(random_op(FN_UNDEF));
                end
            end
            episode++;
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** interval_block_index_fifo: PASSED **");
        end else begin
            $display("** interval_block_index_fifo: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/ibif_pkg.sv
src/ibif_if.sv
src/ibif_ram.sv
src/ibif_ctrl.sv
src/ibif_dp.sv
src/interval_block_index_fifo.sv
verif/interval_block_index_fifo_tb.sv
